// File: rtl/pwd_pkg.sv
// Package for the peer-wire message deframer: phase and kind codes, the result word type
// and the handshake length. It has no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pwd_pkg;

  localparam int unsigned HandshakeBytes = 68;

  typedef enum logic [2:0] {
    PH_HANDSHAKE = 3'd0,
    PH_LEN1      = 3'd1,
    PH_LEN2      = 3'd2,
    PH_LEN3      = 3'd3,
    PH_LEN4      = 3'd4,
    PH_TYPE      = 3'd5,
    PH_PAYLOAD   = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HANDSHAKE = 2'd0,
    KIND_KEEPALIVE = 2'd1,
    KIND_PAYLOAD   = 2'd2,
    KIND_NO_DATA   = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [7:0]  msg_type;
    logic [31:0] msg_length;
    logic [31:0] offset;
    logic        last;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/pwd_in_reg.sv
// Input register of the deframer: holds one received stream byte until the core takes it.
// It has no dependencies.
`timescale 1ns / 1ps
`default_nettype none
module pwd_in_reg (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  output logic            held_valid_o,
  output logic [7:0]      held_byte_o,
  input  wire logic       take_i
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       in_fire;

  assign in_ready_o = !valid_q || take_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign valid_d    = in_fire || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      byte_q <= in_byte_i;
    end
  end

  assign held_valid_o = valid_q;
  assign held_byte_o  = byte_q;

endmodule
`default_nettype wire

// File: rtl/pwd_core.sv
// Framing state machine of the deframer: tracks handshake, length, type and payload
// phases and forms the result word for each byte that gives one. Depends on pwd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pwd_core
  import pwd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       byte_valid_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       out_free_i,
  output logic            take_o,
  output logic            res_valid_o,
  output result_t         res_o
);

  phase_e      phase_q, phase_d;
  logic [31:0] count_q, count_d;
  logic [31:0] len_q, len_d;
  logic [7:0]  type_q, type_d;
  logic        hs_last, pl_last;
  logic [31:0] len_shift;

  assign hs_last   = ({1'b0, count_q} + 33'd1) >= 33'(HandshakeBytes);
  assign pl_last   = ({1'b0, count_q} + 33'd2) >= {1'b0, len_q};
  assign len_shift = {len_q[23:0], byte_i};

  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    len_d       = len_q;
    type_d      = type_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: KIND_HANDSHAKE, data: 8'd0, msg_type: 8'd0,
                    msg_length: 32'd0, offset: 32'd0, last: 1'b0};
    case (phase_q)
      PH_HANDSHAKE: begin
        res_valid_o = 1'b1;
        res_o = '{kind: KIND_HANDSHAKE, data: byte_i, msg_type: 8'd0,
                  msg_length: 32'(HandshakeBytes), offset: count_q, last: hs_last};
        if (hs_last) begin
          count_d = 32'd0;
          phase_d = PH_LEN1;
        end else begin
          count_d = count_q + 32'd1;
        end
      end
      PH_LEN2: begin
        len_d   = len_shift;
        phase_d = PH_LEN3;
      end
      PH_LEN3: begin
        len_d   = len_shift;
        phase_d = PH_LEN4;
      end
      PH_LEN4: begin
        len_d = len_shift;
        if (len_shift == 32'd0) begin
          res_valid_o = 1'b1;
          res_o = '{kind: KIND_KEEPALIVE, data: 8'd0, msg_type: 8'd0,
                    msg_length: 32'd0, offset: 32'd0, last: 1'b1};
          phase_d = PH_LEN1;
        end else begin
          phase_d = PH_TYPE;
        end
      end
      PH_TYPE: begin
        type_d  = byte_i;
        count_d = 32'd0;
        if (len_q == 32'd1) begin
          res_valid_o = 1'b1;
          res_o = '{kind: KIND_NO_DATA, data: 8'd0, msg_type: byte_i,
                    msg_length: len_q, offset: 32'd0, last: 1'b1};
          phase_d = PH_LEN1;
        end else begin
          phase_d = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        res_valid_o = 1'b1;
        res_o = '{kind: KIND_PAYLOAD, data: byte_i, msg_type: type_q,
                  msg_length: len_q, offset: count_q, last: pl_last};
        if (pl_last) begin
          count_d = 32'd0;
          phase_d = PH_LEN1;
        end else begin
          count_d = count_q + 32'd1;
        end
      end
      default: begin
        len_d   = {24'd0, byte_i};
        phase_d = PH_LEN2;
      end
    endcase
  end

  assign take_o = byte_valid_i && (!res_valid_o || out_free_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HANDSHAKE;
      count_q <= 32'd0;
      len_q   <= 32'd0;
      type_q  <= 8'd0;
    end else if (take_o) begin
      phase_q <= phase_d;
      count_q <= count_d;
      len_q   <= len_d;
      type_q  <= type_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/pwd_out_reg.sv
// Result register of the deframer: holds one result word until the sink takes it.
// Depends on pwd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pwd_out_reg
  import pwd_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire result_t res_i,
  output logic         free_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output result_t      res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire

// File: rtl/peer_wire_message_deframer_unit.sv
// Top level of the peer-wire message deframer: input register, framing core, result register.
// Depends on pwd_pkg, pwd_in_reg, pwd_core and pwd_out_reg.
//
//   Channel  Direction  Handshake               Word
//   in       sink       in_valid_i/in_ready_o   in_byte_i
//   out      source     out_valid_o/out_ready_i kind, byte, type, length, offset, last
//
// One byte is accepted per cycle when the sink keeps up. An accepted byte waits in the input register;
// its result enters the result register at the edge that takes the byte from there. Length bytes other
// than a keepalive's last, and type bytes before a payload, give no result and never wait on the sink.
// Reset clears the framing state to the start of the handshake; no clearing pass is needed.
// A stalled result holds the result register; the input keeps one byte more in its register.
`timescale 1ns / 1ps
`default_nettype none
module peer_wire_message_deframer_unit
  import pwd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  in_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       out_kind_o,
  output logic [7:0]       out_byte_o,
  output logic [7:0]       msg_type_out_o,
  output logic [31:0]      msg_length_out_o,
  output logic [31:0]      byte_offset_o,
  output logic             last_o
);

  logic       held_valid;
  logic [7:0] held_byte;
  logic       take;
  logic       res_valid;
  logic       out_free;
  result_t    core_res;
  result_t    out_res;

  pwd_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .held_valid_o (held_valid),
    .held_byte_o  (held_byte),
    .take_i       (take)
  );

  pwd_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (held_valid),
    .byte_i       (held_byte),
    .out_free_i   (out_free),
    .take_o       (take),
    .res_valid_o  (res_valid),
    .res_o        (core_res)
  );

  pwd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take && res_valid),
    .res_i       (core_res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign out_kind_o       = out_res.kind;
  assign out_byte_o       = out_res.data;
  assign msg_type_out_o   = out_res.msg_type;
  assign msg_length_out_o = out_res.msg_length;
  assign byte_offset_o    = out_res.offset;
  assign last_o           = out_res.last;

endmodule
`default_nettype wire

// File: rtl/pwd_checker.sv
// Port-level checks for the peer-wire message deframer, bound to its top level.
// Depends on pwd_pkg and peer_wire_message_deframer_unit.
`timescale 1ns / 1ps
`default_nettype none
module pwd_checker
  import pwd_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [1:0]  out_kind_o,
  input wire logic [7:0]  out_byte_o,
  input wire logic [31:0] msg_length_out_o,
  input wire logic [31:0] byte_offset_o,
  input wire logic        last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(byte_offset_o))
    else $error("A stalled result word changed or vanished.");

  a_keepalive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == KIND_KEEPALIVE |->
      last_o && msg_length_out_o == 32'd0 && out_byte_o == 8'd0)
    else $error("A keepalive word is malformed.");

  a_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == KIND_NO_DATA |-> last_o && msg_length_out_o == 32'd1)
    else $error("A message without payload has a wrong length or no last mark.");

  a_handshake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == KIND_HANDSHAKE |->
      msg_length_out_o == 32'(HandshakeBytes) && byte_offset_o < 32'(HandshakeBytes))
    else $error("A handshake word has a wrong length or offset.");

  a_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == KIND_PAYLOAD |->
      ({1'b0, byte_offset_o} + 33'd2) <= {1'b0, msg_length_out_o})
    else $error("A payload offset lies beyond the declared length.");

endmodule

bind peer_wire_message_deframer_unit pwd_checker u_pwd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .out_kind_o       (out_kind_o),
  .out_byte_o       (out_byte_o),
  .msg_length_out_o (msg_length_out_o),
  .byte_offset_o    (byte_offset_o),
  .last_o           (last_o)
);
`default_nettype wire

// File: tb/peer_wire_message_deframer_unit_tb.sv
// Testbench for peer_wire_message_deframer_unit: drives a handshake and then framed messages
// with random content and stalls, and checks every result word against a built-in predictor.
// Depends on pwd_pkg and the deframer RTL.
`timescale 1ns / 1ps
module peer_wire_message_deframer_unit_tb;
  import pwd_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  in_byte_i = 8'd0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  out_kind_o;
  logic [7:0]  out_byte_o;
  logic [7:0]  msg_type_out_o;
  logic [31:0] msg_length_out_o;
  logic [31:0] byte_offset_o;
  logic        last_o;

  phase_e      deframe_phase = PH_HANDSHAKE;
  logic [31:0] deframe_count = '0;
  logic [31:0] deframe_length = '0;
  logic [7:0]  deframe_type = '0;
  result_t     deframed_q[$];

  bit          bursts_on = 1'b1;
  int unsigned stall_left = 0;
  int unsigned bytes_sent = 0;
  int unsigned mismatch_count = 0;
  result_t     want;

  peer_wire_message_deframer_unit i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .in_byte_i        (in_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_kind_o       (out_kind_o),
    .out_byte_o       (out_byte_o),
    .msg_type_out_o   (msg_type_out_o),
    .msg_length_out_o (msg_length_out_o),
    .byte_offset_o    (byte_offset_o),
    .last_o           (last_o)
  );

  always #2 clk_i = ~clk_i;

  task automatic deframe_byte(input logic [7:0] b);
    result_t r;
    r = '0;
    case (deframe_phase)
      PH_HANDSHAKE: begin
        r.kind       = KIND_HANDSHAKE;
        r.data       = b;
        r.msg_length = HandshakeBytes;
        r.offset     = deframe_count;
        r.last       = (33'(deframe_count) + 33'd1 >= 33'(HandshakeBytes));
        deframed_q.push_back(r);
        if (r.last) begin
          deframe_count = '0;
          deframe_phase = PH_LEN1;
        end else begin
          deframe_count++;
        end
      end
      PH_LEN2: begin
        deframe_length = {deframe_length[23:0], b};
        deframe_phase  = PH_LEN3;
      end
      PH_LEN3: begin
        deframe_length = {deframe_length[23:0], b};
        deframe_phase  = PH_LEN4;
      end
      PH_LEN4: begin
        deframe_length = {deframe_length[23:0], b};
        if (deframe_length == 32'd0) begin
          r.kind = KIND_KEEPALIVE;
          r.last = 1'b1;
          deframed_q.push_back(r);
          deframe_phase = PH_LEN1;
        end else begin
          deframe_phase = PH_TYPE;
        end
      end
      PH_TYPE: begin
        deframe_type  = b;
        deframe_count = '0;
        if (deframe_length == 32'd1) begin
          r.kind       = KIND_NO_DATA;
          r.msg_type   = deframe_type;
          r.msg_length = deframe_length;
          r.last       = 1'b1;
          deframed_q.push_back(r);
          deframe_phase = PH_LEN1;
        end else begin
          deframe_phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        r.kind       = KIND_PAYLOAD;
        r.data       = b;
        r.msg_type   = deframe_type;
        r.msg_length = deframe_length;
        r.offset     = deframe_count;
        r.last       = (33'(deframe_count) + 33'd2 >= 33'(deframe_length));
        deframed_q.push_back(r);
        if (r.last) begin
          deframe_count = '0;
          deframe_phase = PH_LEN1;
        end else begin
          deframe_count++;
        end
      end
      default: begin
        deframe_length = {24'd0, b};
        deframe_phase  = PH_LEN2;
      end
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = 0;
    if (bursts_on && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 12);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_byte_i  = b;
    do @(posedge clk_i); while (!in_ready_o);
    deframe_byte(b);
    bytes_sent++;
  endtask

  task automatic send_length(input logic [31:0] len);
    send_byte(len[31:24]);
    send_byte(len[23:16]);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
  endtask

  task automatic send_message(input logic [31:0] len, input logic [7:0] kind_byte);
    send_length(len);
    if (len != 32'd0) begin
      send_byte(kind_byte);
      for (int unsigned i = 1; i < len; i++) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_random_messages(input int unsigned count);
    int unsigned stop_at;
    int unsigned pick;
    logic [31:0] len;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) len = 32'd0;
      else if (pick < 25) len = 32'd1;
      else if (pick < 88) len = $urandom_range(2, 20);
      else len = $urandom_range(21, 300);
      send_message(len, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_handshake();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_byte(8'hAA);
    for (int unsigned i = 4; i < HandshakeBytes; i++) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic test_short_messages();
    send_message(32'd0, 8'h00);
    send_message(32'd1, 8'h00);
    send_message(32'd1, 8'hFF);
    send_length(32'd2);
    send_byte(8'h07);
    send_byte(8'hFF);
    send_length(32'd3);
    send_byte(8'h05);
    send_byte(8'h00);
    send_byte(8'h80);
  endtask

  task automatic test_random_stream();
    bursts_on = 1'b1;
    send_random_messages(1500);
  endtask

  task automatic test_steady_stream();
    bursts_on = 1'b0;
    send_random_messages(250);
  endtask

  // The stream ends inside this message, so only its first payload words come out.
  task automatic test_largest_length();
    send_length(32'hFFFF_FFFF);
    send_byte(8'($urandom_range(0, 255)));
    repeat (6) send_byte(8'($urandom_range(0, 255)));
  endtask

  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i = 1'b0;
      stall_left--;
    end else if (bursts_on && $urandom_range(0, 7) == 0) begin
      stall_left  = $urandom_range(0, 11);
      out_ready_i = 1'b0;
    end else begin
      out_ready_i = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (deframed_q.size() == 0) begin
        $error("result word with none expected: kind %0d byte %h", out_kind_o, out_byte_o);
        mismatch_count++;
      end else begin
        want = deframed_q.pop_front();
        if (2'(want.kind) !== out_kind_o) begin
          $error("out_kind: expected %0d, actual %0d", want.kind, out_kind_o);
          mismatch_count++;
        end
        if (want.data !== out_byte_o) begin
          $error("out_byte: expected %h, actual %h", want.data, out_byte_o);
          mismatch_count++;
        end
        if (want.msg_type !== msg_type_out_o) begin
          $error("msg_type_out: expected %h, actual %h", want.msg_type, msg_type_out_o);
          mismatch_count++;
        end
        if (want.msg_length !== msg_length_out_o) begin
          $error("msg_length_out: expected %0d, actual %0d", want.msg_length,
                 msg_length_out_o);
          mismatch_count++;
        end
        if (want.offset !== byte_offset_o) begin
          $error("byte_offset: expected %0d, actual %0d", want.offset, byte_offset_o);
          mismatch_count++;
        end
        if (want.last !== last_o) begin
          $error("last: expected %0d, actual %0d", want.last, last_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_handshake();
    test_short_messages();
    test_random_stream();
    test_steady_stream();
    test_largest_length();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (deframed_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (deframed_q.size() != 0) begin
      $error("%0d result words still expected", deframed_q.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
